### rtl/plir_pkg.sv
// Package for the positional list engine.
// Holds the operation and status codes, the cell command struct and shared widths.
// No dependencies.
package plir_pkg;

  // Fixed widths of the item fields.
  localparam int MODE_W     = 2;
  localparam int POSITION_W = 7;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEF         = 64;
  localparam int ELEMENT_WIDTH_DEF = 32;

  // Number of read taps folded together in the first stage of the read tree.
  localparam int GROUP_SIZE = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_WRITE  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What every cell does at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_WRITE  = 2'd3
  } cell_op_t;

  // Command broadcast along the chain.
  typedef struct packed {
    cell_op_t                op;
    logic                    rd;
    logic [POSITION_W-1:0]   position;
  } cell_cmd_t;

endpackage

### rtl/plir_cell.sv
// One list slot of the positional list engine.
// Holds a single entry and takes its neighbor's entry on a shift.
// Depends on plir_pkg.
module plir_cell #(
  parameter int INDEX         = 0,
  parameter int ELEMENT_WIDTH = plir_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  plir_pkg::cell_cmd_t      cmd,
  input  logic [ELEMENT_WIDTH-1:0] load_value,
  input  logic [ELEMENT_WIDTH-1:0] left_data,
  input  logic [ELEMENT_WIDTH-1:0] right_data,
  output logic [ELEMENT_WIDTH-1:0] data,
  output logic [ELEMENT_WIDTH-1:0] read_tap
);
  import plir_pkg::*;

  localparam logic [31:0] IDX = 32'(INDEX);

  logic [31:0]              pos_ext;
  logic                     at_pos;
  logic                     above_pos;
  logic [ELEMENT_WIDTH-1:0] data_next;

  // Compare this slot's index against the broadcast position.
  assign pos_ext   = 32'(cmd.position);
  assign at_pos    = (IDX == pos_ext);
  assign above_pos = (IDX > pos_ext);

  // Pick the new entry for this slot.
  always_comb begin
    data_next = data;
    unique case (cmd.op)
      CELL_INSERT: begin
        if (above_pos) begin
          data_next = left_data;
        end else if (at_pos) begin
          data_next = load_value;
        end
      end
      CELL_REMOVE: begin
        if (above_pos || at_pos) begin
          data_next = right_data;
        end
      end
      CELL_WRITE: begin
        if (at_pos) begin
          data_next = load_value;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  // Entry register; reset empties the slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else begin
      data <= data_next;
    end
  end

  // The addressed slot shows its entry on the read tap for one cycle.
  always_ff @(posedge clk) begin
    if (cmd.rd && at_pos) begin
      read_tap <= data;
    end else begin
      read_tap <= '0;
    end
  end

endmodule

### rtl/plir_or_tree.sv
// Two-stage registered OR tree that gathers the read taps of the cell chain.
// At most one tap is nonzero, so the OR yields the addressed entry.
// Depends on plir_pkg.
module plir_or_tree #(
  parameter int DEPTH         = plir_pkg::DEPTH_DEF,
  parameter int ELEMENT_WIDTH = plir_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic [ELEMENT_WIDTH-1:0] taps [DEPTH],
  output logic [ELEMENT_WIDTH-1:0] result
);
  import plir_pkg::*;

  localparam int NUM_GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [ELEMENT_WIDTH-1:0] group_next [NUM_GROUPS];
  logic [ELEMENT_WIDTH-1:0] group_or   [NUM_GROUPS];
  logic [ELEMENT_WIDTH-1:0] result_next;

  // First stage: fold each group of taps.
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_next[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < DEPTH) begin
          group_next[g] = group_next[g] | taps[g * GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_or[g] <= group_next[g];
    end
  end

  // Second stage: fold the groups.
  always_comb begin
    result_next = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      result_next = result_next | group_or[g];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

### rtl/positional_list_insert_remove.sv
// Top level of the positional list engine: a chain of list cells, the command
// decoder with the entry count, and the read tree with the result registers.
// Depends on plir_pkg, plir_cell and plir_or_tree.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------
//   command  | start / busy       | mode, position, value
//   result   | done (one cycle)   | read_value, status, count
//
// A command transfer completes on an edge with start high and busy low.
// All cells shift or load on that same edge; the result is shown with done
// after the read tap register and the two stages of the read OR tree.
// busy stays high while a transfer is in stage1 or stage2, so no new command
// is taken until the last one has left stage2; these stages track the tree.
// rst is synchronous: it empties the list and clears the control pipeline.
// The receiver cannot stall, so done is never held.
module positional_list_insert_remove #(
  parameter int DEPTH         = plir_pkg::DEPTH_DEF,
  parameter int ELEMENT_WIDTH = plir_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [plir_pkg::MODE_W-1:0]       mode,
  input  logic [plir_pkg::POSITION_W-1:0]   position,
  input  logic [plir_pkg::VALUE_W-1:0]      value,
  output logic                              done,
  output logic [plir_pkg::VALUE_W-1:0]      read_value,
  output logic [plir_pkg::STATUS_W-1:0]     status,
  output logic [plir_pkg::COUNT_W-1:0]      count
);
  import plir_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

  logic                     accept;
  logic [CNT_W-1:0]         entry_count;
  logic [CNT_W-1:0]         entry_count_next;
  logic [CMP_W-1:0]         pos_c;
  logic [CMP_W-1:0]         cnt_c;
  logic                     full;
  status_t                  status_next;
  cell_cmd_t                cmd;
  logic [ELEMENT_WIDTH-1:0] load_value;

  logic                     stage1;
  logic                     stage2;
  status_t                  status_s1;
  status_t                  status_s2;
  logic [COUNT_W-1:0]       count_s1;
  logic [COUNT_W-1:0]       count_s2;

  logic [ELEMENT_WIDTH-1:0] cell_data [DEPTH];
  logic [ELEMENT_WIDTH-1:0] cell_tap  [DEPTH];
  logic [ELEMENT_WIDTH-1:0] tree_result;

  assign accept     = start && !busy;
  assign busy       = stage1 || stage2;
  assign pos_c      = CMP_W'(position);
  assign cnt_c      = CMP_W'(entry_count);
  assign full       = (cnt_c == CMP_W'(DEPTH));
  assign load_value = ELEMENT_WIDTH'(value);

  // Decode the command against the current count.
  always_comb begin
    status_next      = ST_OK;
    entry_count_next = entry_count;
    cmd.op           = CELL_HOLD;
    cmd.rd           = 1'b0;
    cmd.position     = position;
    if (accept) begin
      unique case (mode_t'(mode))
        MODE_INSERT: begin
          if (pos_c > cnt_c) begin
            status_next = ST_RANGE;
          end else if (full) begin
            status_next = ST_FULL;
          end else begin
            cmd.op           = CELL_INSERT;
            entry_count_next = entry_count + CNT_W'(1);
          end
        end
        MODE_REMOVE: begin
          if (pos_c >= cnt_c) begin
            status_next = ST_RANGE;
          end else begin
            cmd.op           = CELL_REMOVE;
            entry_count_next = entry_count - CNT_W'(1);
          end
        end
        MODE_READ: begin
          if (pos_c >= cnt_c) begin
            status_next = ST_RANGE;
          end else begin
            cmd.rd = 1'b1;
          end
        end
        MODE_WRITE: begin
          if (pos_c < cnt_c) begin
            cmd.op = CELL_WRITE;
          end else if (pos_c == cnt_c) begin
            if (full) begin
              status_next = ST_FULL;
            end else begin
              cmd.op           = CELL_WRITE;
              entry_count_next = entry_count + CNT_W'(1);
            end
          end else begin
            status_next = ST_RANGE;
          end
        end
        default: begin
          status_next = ST_RANGE;
        end
      endcase
    end
  end

  // Entry count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else begin
      entry_count <= entry_count_next;
    end
  end

  // Chain of list cells; the ends see an empty neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] left_in;
    logic [ELEMENT_WIDTH-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_left
      assign left_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_right
      assign right_in = cell_data[i+1];
    end
    plir_cell #(
      .INDEX         (i),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .load_value (load_value),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .read_tap   (cell_tap[i])
    );
  end

  // Read tree that gathers the addressed entry.
  plir_or_tree #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_tree (
    .clk    (clk),
    .taps   (cell_tap),
    .result (tree_result)
  );

  // Control pipeline that tracks the command through the read tree.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= accept;
      stage2 <= stage1;
      done   <= stage2;
    end
  end

  // Status and count ride alongside the read tree.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_s1 <= status_next;
      count_s1  <= COUNT_W'(entry_count_next);
    end
    status_s2 <= status_s1;
    count_s2  <= count_s1;
    status    <= status_s2;
    count     <= count_s2;
  end

  assign read_value = VALUE_W'(tree_result);

endmodule

### rtl/plir_checker.sv
// Port-level checker for the positional list engine, bound to the top level.
// Depends on plir_pkg and positional_list_insert_remove.
module plir_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic [plir_pkg::VALUE_W-1:0]      read_value,
  input logic [plir_pkg::STATUS_W-1:0]     status
);
  import plir_pkg::*;

  // Every command transfer yields its result, with done raised once the transfer has left the control pipeline.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result did not follow a command transfer");

  // A transfer blocks further commands while it is in flight.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after a command transfer");

  // Results never come back to back.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  // The status code is one of the defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_RANGE || status == ST_FULL))
    else $error("undefined status code");

  // A failed operation returns no data.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (read_value == '0))
    else $error("read data on a failed operation");

endmodule

bind positional_list_insert_remove plir_checker u_plir_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .read_value (read_value),
  .status     (status)
);
